// File: sv/tlnef_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlnef_pkg
// Shared types and constants for the text line number and escape filter.
// ----------------------------------------------------------------------------
package tlnef_pkg;

    // BCD digits kept for the line counter; the count never passes 999999
    localparam int MAX_CNT_DIGITS = 6;

    // descriptor queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W = 3;

    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_NL       = 8'd10;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_DOLLAR   = 8'd36;
    localparam logic [7:0] CH_QMARK    = 8'd63;
    localparam logic [7:0] CH_CARET    = 8'd94;
    localparam logic [7:0] CH_DEL      = 8'd127;
    localparam logic [7:0] CTRL_OFFSET = 8'd64;
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;
    localparam logic [3:0] BCD_NINE    = 4'd9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUMBER_ALL       = 3'd0,
        CFG_NUMBER_NONBLANK  = 3'd1,
        CFG_SQUEEZE_BLANK    = 3'd2,
        CFG_SHOW_ENDS        = 3'd3,
        CFG_SHOW_TABS        = 3'd4,
        CFG_SHOW_NONPRINTING = 3'd5
    } t_cfg_idx;

    typedef logic [3:0] t_bcd;

    // one classified input byte, ready to be expanded into output beats
    typedef struct packed {
        logic                           pfx_en;
        logic                           pfx_sp;
        t_bcd [MAX_CNT_DIGITS-1:0]      digits;
        logic                           mark_en;
        logic [7:0]                     mark;
        logic [7:0]                     last_byte;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

endpackage
`default_nettype wire

// File: sv/tlnef_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlnef_front
// Accepts input bytes, tracks line state and the BCD line counter, and
// classifies each byte into a descriptor for the back end.
// ----------------------------------------------------------------------------
module tlnef_front
    import tlnef_pkg::*;
#(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic                 i_cfg_data,
    input  wire logic                 i_push,
    input  wire logic [7:0]           i_in_byte,
    input  wire logic                 i_file_start,
    input  wire logic                 i_full,
    output logic                      o_q_push,
    output t_item                     o_q_item
);

    localparam int CntDigits = (NUMBER_DIGITS < MAX_CNT_DIGITS) ? NUMBER_DIGITS
                                                                : MAX_CNT_DIGITS;

    logic r_number_all, r_number_nonblank, r_squeeze_blank;
    logic r_show_ends, r_show_tabs, r_show_nonprinting;

    t_bcd [MAX_CNT_DIGITS-1:0] r_cnt, n_cnt;
    logic [2:0]                r_blank_run, n_blank_run;

    t_bcd [MAX_CNT_DIGITS-1:0] cnt_cur, cnt_inc;
    logic [2:0] run_cur, run_sum;
    logic accept, is_nl, is_ctrl, drop, at_start, eff_all, pfx_num, pfx_sp, sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_all       <= 1'b0;
            r_number_nonblank  <= 1'b0;
            r_squeeze_blank    <= 1'b0;
            r_show_ends        <= 1'b0;
            r_show_tabs        <= 1'b0;
            r_show_nonprinting <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUMBER_ALL:       r_number_all       <= i_cfg_data;
                CFG_NUMBER_NONBLANK:  r_number_nonblank  <= i_cfg_data;
                CFG_SQUEEZE_BLANK:    r_squeeze_blank    <= i_cfg_data;
                CFG_SHOW_ENDS:        r_show_ends        <= i_cfg_data;
                CFG_SHOW_TABS:        r_show_tabs        <= i_cfg_data;
                CFG_SHOW_NONPRINTING: r_show_nonprinting <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic carry;
        carry = 1'b1;

        accept = i_push && !i_full;

        cnt_cur = r_cnt;
        run_cur = r_blank_run;
        if (i_file_start) begin
            cnt_cur    = '0;
            cnt_cur[0] = 4'd1;
            run_cur    = 3'd1;
        end

        is_nl    = (i_in_byte == CH_NL);
        is_ctrl  = (i_in_byte < CH_SPACE) && (i_in_byte != CH_TAB) && !is_nl;
        drop     = is_nl && r_squeeze_blank && (run_cur > 3'd2);
        at_start = (run_cur != 3'd0) && !drop;
        eff_all  = r_number_all && !r_number_nonblank;
        pfx_num  = at_start && (eff_all || (r_number_nonblank && !is_nl));
        pfx_sp   = at_start && r_number_nonblank && r_show_ends && is_nl;

        // hold at the all-nines value of the printed width
        sat = 1'b1;
        for (int i = 0; i < MAX_CNT_DIGITS; i++) begin
            if (i < CntDigits && cnt_cur[i] != BCD_NINE) sat = 1'b0;
        end

        for (int i = 0; i < MAX_CNT_DIGITS; i++) begin
            cnt_inc[i] = cnt_cur[i];
            if (carry) begin
                if (cnt_cur[i] == BCD_NINE) begin
                    cnt_inc[i] = 4'd0;
                end else begin
                    cnt_inc[i] = cnt_cur[i] + 4'd1;
                    carry      = 1'b0;
                end
            end
        end

        n_cnt = (pfx_num && !sat) ? cnt_inc : cnt_cur;

        // a kept newline under squeeze advances the tracker twice
        run_sum = (r_squeeze_blank && run_cur <= 3'd2) ? run_cur + 3'd2
                                                       : run_cur + 3'd1;
        if (!is_nl) begin
            n_blank_run = 3'd0;
        end else if (run_sum > 3'd4) begin
            n_blank_run = 3'd4;
        end else begin
            n_blank_run = run_sum;
        end

        o_q_item.pfx_en    = pfx_num || pfx_sp;
        o_q_item.pfx_sp    = pfx_sp;
        o_q_item.digits    = cnt_cur;
        o_q_item.mark_en   = 1'b0;
        o_q_item.mark      = CH_DOLLAR;
        o_q_item.last_byte = i_in_byte;
        if (is_nl && r_show_ends) begin
            o_q_item.mark_en = 1'b1;
        end else if (r_show_nonprinting && is_ctrl) begin
            o_q_item.mark_en   = 1'b1;
            o_q_item.mark      = CH_CARET;
            o_q_item.last_byte = i_in_byte + CTRL_OFFSET;
        end else if (r_show_tabs && i_in_byte == CH_TAB) begin
            o_q_item.mark_en   = 1'b1;
            o_q_item.mark      = CH_CARET;
            o_q_item.last_byte = i_in_byte + CTRL_OFFSET;
        end else if (r_show_nonprinting && i_in_byte == CH_DEL) begin
            o_q_item.mark_en   = 1'b1;
            o_q_item.mark      = CH_CARET;
            o_q_item.last_byte = CH_QMARK;
        end

        // a squeezed newline yields no beats and never enters the queue
        o_q_push = accept && !drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= {{(MAX_CNT_DIGITS-1){4'd0}}, 4'd1};
            r_blank_run <= 3'd1;
        end else if (accept) begin
            r_cnt       <= n_cnt;
            r_blank_run <= n_blank_run;
        end
    end

endmodule
`default_nettype wire

// File: sv/tlnef_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlnef_queue
// Short descriptor queue that decouples the classifier from the expander.
// ----------------------------------------------------------------------------
module tlnef_queue
    import tlnef_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output logic       o_full,
    output t_q_head    o_head
);

    localparam int QIw = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_item           r_mem [QUEUE_DEPTH];
    logic [QIw-1:0]  r_wr, r_rd;
    logic [CntW-1:0] r_count;

    assign o_full       = (r_count == CntW'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == QIw'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == QIw'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: sv/tlnef_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlnef_back
// Expands the head descriptor into output beats, one per cycle while the output
// is empty or popped, through an output register.
// ----------------------------------------------------------------------------
module tlnef_back
    import tlnef_pkg::*;
#(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_head i_head,
    output logic         o_q_pop,
    input  wire logic    i_pop,
    output logic         o_empty,
    output logic [7:0]   o_out_byte,
    output logic         o_last_of_run
);

    localparam int CntDigits = (NUMBER_DIGITS < MAX_CNT_DIGITS) ? NUMBER_DIGITS
                                                                : MAX_CNT_DIGITS;
    localparam int PhW = $clog2(NUMBER_DIGITS + 3);
    localparam logic [PhW-1:0] PhTab  = PhW'(NUMBER_DIGITS);
    localparam logic [PhW-1:0] PhMark = PhW'(NUMBER_DIGITS + 1);
    localparam logic [PhW-1:0] PhLast = PhW'(NUMBER_DIGITS + 2);

    logic [PhW-1:0] r_phase, n_phase, cur_phase;
    logic           r_busy;
    logic           r_out_valid;
    logic [7:0]     r_out_byte, n_byte;
    logic           r_out_last;
    logic           step, at_last;
    logic [7:0]     w_dig_char [NUMBER_DIGITS];

    // leftmost character is phase 0; blank leading zeros above the units digit
    for (genvar gp = 0; gp < NUMBER_DIGITS; gp++) begin : g_dig
        localparam int Pos = NUMBER_DIGITS - 1 - gp;
        if (Pos >= CntDigits) begin : g_pad
            assign w_dig_char[gp] = CH_SPACE;
        end else if (Pos == 0) begin : g_units
            assign w_dig_char[gp] = i_head.item.pfx_sp ? CH_SPACE
                                  : {ASCII_DIGIT_HI, i_head.item.digits[0]};
        end else begin : g_upper
            assign w_dig_char[gp] =
                (i_head.item.pfx_sp || (i_head.item.digits[CntDigits-1:Pos] == '0))
                ? CH_SPACE : {ASCII_DIGIT_HI, i_head.item.digits[Pos]};
        end
    end

    always_comb begin
        cur_phase = r_phase;
        if (!r_busy) begin
            if (i_head.item.pfx_en)       cur_phase = '0;
            else if (i_head.item.mark_en) cur_phase = PhMark;
            else                          cur_phase = PhLast;
        end

        if (cur_phase < PhTab) begin
            n_phase = cur_phase + 1'b1;
        end else if (cur_phase == PhTab) begin
            n_phase = i_head.item.mark_en ? PhMark : PhLast;
        end else begin
            n_phase = PhLast;
        end

        n_byte = i_head.item.last_byte;
        if (cur_phase < PhTab) begin
            for (int p = 0; p < NUMBER_DIGITS; p++) begin
                if (cur_phase == PhW'(p)) n_byte = w_dig_char[p];
            end
        end else if (cur_phase == PhTab) begin
            n_byte = CH_TAB;
        end else if (cur_phase == PhMark) begin
            n_byte = i_head.item.mark;
        end

        at_last = (cur_phase == PhLast);
        step    = i_head.valid && (!r_out_valid || i_pop);
        o_q_pop = step && at_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_busy      <= !at_last;
                r_phase     <= n_phase;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_byte <= n_byte;
            r_out_last <= at_last;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

endmodule
`default_nettype wire

// File: sv/text_line_number_escape_filter_unit.sv
`default_nettype none
// An item is registered in the descriptor queue, then its beats in the output register.
// The expander gives one output beat per cycle while the output is popped; an item yields 1 to
// NUMBER_DIGITS + 3 beats, a squeezed newline none.
// The two-entry descriptor queue lets input bytes keep arriving while beats drain.
// Reset (synchronous, active low): line counter to 1, at line start, all options off,
// queue and output empty.
// ----------------------------------------------------------------------------
// text_line_number_escape_filter_unit
// Cat-style rewriting of a byte stream: line numbers, squeeze, end marks and
// caret escapes, with a classifier front, a descriptor queue and an expander.
// ----------------------------------------------------------------------------
module text_line_number_escape_filter_unit
    import tlnef_pkg::*;
#(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic                 i_cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [7:0]           i_in_byte,
    input  wire logic                 i_file_start,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [7:0]                o_out_byte,
    output logic                      o_last_of_run
);

    logic    w_q_push, w_q_pop;
    t_item   w_q_item;
    t_q_head w_head;

    tlnef_front #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_in_byte   (i_in_byte),
        .i_file_start(i_file_start),
        .i_full      (full),
        .o_q_push    (w_q_push),
        .o_q_item    (w_q_item)
    );

    tlnef_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_q_push),
        .i_item (w_q_item),
        .i_pop  (w_q_pop),
        .o_full (full),
        .o_head (w_head)
    );

    tlnef_back #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .o_q_pop      (w_q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_last_of_run(o_last_of_run)
    );

`ifndef SYNTHESIS
    // a beat that is not the last of its run is followed at once by the next one
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !empty && !o_last_of_run |=> !empty)
        else $error("output run broken before its last beat");

    // no beat appears without a descriptor at the queue head
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_head.valid && (empty || pop) |=> empty)
        else $error("output beat without a queued descriptor");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queue or output not cleared by reset");
`endif

endmodule
`default_nettype wire

// File: test/tb_text_line_number_escape_filter_unit.sv
// ----------------------------------------------------------------------------
// tb_text_line_number_escape_filter_unit
// Drives byte streams through the cat-style filter under several option
// settings and checks every output beat against an in-bench prediction of the
// numbering, squeeze, end-mark and caret rewriting rules.
// ----------------------------------------------------------------------------
module tb_text_line_number_escape_filter_unit;
    import tlnef_pkg::*;

    localparam int NUM_DIGITS    = 6;
    localparam int LINE_NO_MAX   = 10**NUM_DIGITS - 1;
    localparam int SETTLE_CYCLES = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_cat_beat;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic                 i_cfg_data;
    logic                 push;
    logic                 full;
    logic [7:0]           i_in_byte;
    logic                 i_file_start;
    logic                 empty;
    logic                 pop;
    logic [7:0]           o_out_byte;
    logic                 o_last_of_run;

    // predicted filter state
    logic [5:0]  opts;
    logic [19:0] line_no;
    logic [2:0]  line_start;
    t_cat_beat   cat_beats_q[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int n_errors;

    text_line_number_escape_filter_unit #(
        .NUMBER_DIGITS(NUM_DIGITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_in_byte     (i_in_byte),
        .i_file_start  (i_file_start),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic void emit_beat(logic [7:0] b);
        t_cat_beat beat;
        beat.data = b;
        beat.last = 1'b0;
        cat_beats_q.push_back(beat);
    endfunction

    function automatic void emit_line_number();
        logic [7:0]  digit_ch[NUM_DIGITS];
        logic [19:0] v;
        v = line_no;
        for (int d = NUM_DIGITS - 1; d >= 0; d--) begin
            if (v != 0 || d == NUM_DIGITS - 1) begin
                digit_ch[d] = {ASCII_DIGIT_HI, 4'(v % 10)};
                v = 20'(v / 10);
            end else begin
                digit_ch[d] = CH_SPACE;
            end
        end
        for (int d = 0; d < NUM_DIGITS; d++) begin
            emit_beat(digit_ch[d]);
        end
        emit_beat(CH_TAB);
        if (line_no < LINE_NO_MAX) begin
            line_no++;
        end
    endfunction

    function automatic void emit_line_prefix(logic [7:0] c, int run);
        if (run == 0) begin
            return;
        end
        if (opts[CFG_NUMBER_ALL] && !opts[CFG_NUMBER_NONBLANK]) begin
            emit_line_number();
        end
        if (opts[CFG_NUMBER_NONBLANK] && c != CH_NL) begin
            emit_line_number();
        end else if (opts[CFG_NUMBER_NONBLANK] && opts[CFG_SHOW_ENDS] && c == CH_NL) begin
            // blank line marker in place of a number
            repeat (NUM_DIGITS) emit_beat(CH_SPACE);
            emit_beat(CH_TAB);
        end
    endfunction

    // append the beats one accepted byte turns into
    function automatic void rewrite_byte(logic [7:0] c_in, logic fs);
        logic [7:0] c;
        int         run;
        int         n0;
        c = c_in;
        if (fs) begin
            line_no    = 20'd1;
            line_start = 3'd1;
        end
        run = int'(line_start);
        n0  = cat_beats_q.size();
        if (c_in == CH_NL && opts[CFG_SQUEEZE_BLANK]) begin
            if (run <= 2) begin
                emit_line_prefix(c_in, run);
                if (opts[CFG_SHOW_ENDS]) begin
                    emit_beat(CH_DOLLAR);
                end
                emit_beat(c_in);
                run++;
            end
        end else begin
            emit_line_prefix(c_in, run);
            if (opts[CFG_SHOW_ENDS] && c_in == CH_NL) begin
                emit_beat(CH_DOLLAR);
            end
            if (opts[CFG_SHOW_NONPRINTING] && c < CH_SPACE && c != CH_TAB && c != CH_NL) begin
                emit_beat(CH_CARET);
                c = c + CTRL_OFFSET;
            end
            if (opts[CFG_SHOW_TABS] && c == CH_TAB) begin
                emit_beat(CH_CARET);
                c = c + CTRL_OFFSET;
            end
            if (opts[CFG_SHOW_NONPRINTING] && c == CH_DEL) begin
                emit_beat(CH_CARET);
                c = CH_QMARK;
            end
            emit_beat(c);
        end
        run++;
        if (c_in != CH_NL) begin
            run = 0;
        end
        line_start = (run > 4) ? 3'd4 : 3'(run);
        if (cat_beats_q.size() > n0) begin
            cat_beats_q[$].last = 1'b1;
        end
    endfunction

    task automatic send_byte(logic [7:0] b, logic fs);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push         = 1'b1;
        i_in_byte    = b;
        i_file_start = fs;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        rewrite_byte(b, fs);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        push = 1'b0;
        while (cat_beats_q.size() != 0) @(posedge i_clk);
        // squeezed newlines give no beat; let them clear the pipe
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        case (idx)
            CFG_NUMBER_ALL, CFG_NUMBER_NONBLANK, CFG_SQUEEZE_BLANK,
            CFG_SHOW_ENDS, CFG_SHOW_TABS, CFG_SHOW_NONPRINTING: opts[idx] = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic apply_options(logic [5:0] o);
        wait_idle();
        write_reg(CFG_NUMBER_ALL,       o[CFG_NUMBER_ALL]);
        write_reg(CFG_NUMBER_NONBLANK,  o[CFG_NUMBER_NONBLANK]);
        write_reg(CFG_SQUEEZE_BLANK,    o[CFG_SQUEEZE_BLANK]);
        write_reg(CFG_SHOW_ENDS,        o[CFG_SHOW_ENDS]);
        write_reg(CFG_SHOW_TABS,        o[CFG_SHOW_TABS]);
        write_reg(CFG_SHOW_NONPRINTING, o[CFG_SHOW_NONPRINTING]);
        // unmapped indexes must leave the options alone
        write_reg(CFG_IDX_SPARE_LO, 1'b1);
        write_reg(CFG_IDX_SPARE_HI, 1'b1);
    endtask

    function automatic logic [7:0] random_text_byte();
        case ($urandom_range(9))
            0:       return CH_TAB;
            1:       return 8'($urandom_range(31));
            2:       return CH_DEL;
            3:       return 8'($urandom_range(255, 128));
            4:       return 8'($urandom_range(255));
            default: return 8'($urandom_range(126, 32));
        endcase
    endfunction

    task automatic test_plain_bytes();
        apply_options('0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte("A", 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_DEL, 1'b0);
        send_byte(CH_NL, 1'b0);
    endtask

    task automatic test_caret_escapes();
        logic [5:0] o;
        o = '0;
        o[CFG_SHOW_NONPRINTING] = 1'b1;
        o[CFG_SHOW_TABS]        = 1'b1;
        o[CFG_SHOW_ENDS]        = 1'b1;
        apply_options(o);
        send_byte(8'h01, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_DEL, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_NL, 1'b0);
    endtask

    task automatic test_squeezed_numbering();
        logic [5:0] o;
        o = '0;
        o[CFG_NUMBER_ALL]    = 1'b1;
        o[CFG_SQUEEZE_BLANK] = 1'b1;
        apply_options(o);
        send_byte("x", 1'b1);
        repeat (4) send_byte(CH_NL, 1'b0);
        send_byte("y", 1'b0);
    endtask

    task automatic test_blank_marker();
        logic [5:0] o;
        o = '0;
        o[CFG_NUMBER_ALL]      = 1'b1;
        o[CFG_NUMBER_NONBLANK] = 1'b1;
        o[CFG_SHOW_ENDS]       = 1'b1;
        apply_options(o);
        send_byte("a", 1'b1);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte("b", 1'b0);
    endtask

    // mostly whole lines and blank runs, with partial lines and stray file starts
    task automatic test_random_text(logic [5:0] o, int n_items);
        int  n_sent;
        int  len;
        logic fs;
        n_sent = 0;
        apply_options(o);
        while (n_sent < n_items) begin
            fs = ($urandom_range(29) == 0);
            case ($urandom_range(9))
                0, 1: begin
                    repeat ($urandom_range(5, 1)) begin
                        send_byte(CH_NL, fs);
                        fs = 1'b0;
                        n_sent++;
                    end
                end
                2: begin
                    repeat ($urandom_range(4, 1)) begin
                        send_byte(random_text_byte(), $urandom_range(9) == 0);
                        n_sent++;
                    end
                end
                default: begin
                    len = $urandom_range(8);
                    repeat (len) begin
                        send_byte(random_text_byte(), fs);
                        fs = 1'b0;
                        n_sent++;
                    end
                    send_byte(CH_NL, fs);
                    n_sent++;
                end
            endcase
        end
    endtask

    // result side: random pop, compare each accepted beat
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            pop = ($urandom_range(99) >= rx_idle_pct);
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (cat_beats_q.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, actual %h last %b",
                             $time, o_out_byte, o_last_of_run);
                    n_errors++;
                end else begin
                    if (o_out_byte !== cat_beats_q[0].data) begin
                        $display("%0t: out_byte mismatch: expected %h, actual %h",
                                 $time, cat_beats_q[0].data, o_out_byte);
                        n_errors++;
                    end
                    if (o_last_of_run !== cat_beats_q[0].last) begin
                        $display("%0t: last_of_run mismatch: expected %b, actual %b",
                                 $time, cat_beats_q[0].last, o_last_of_run);
                        n_errors++;
                    end
                    void'(cat_beats_q.pop_front());
                end
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = 1'b0;
        push         = 1'b0;
        i_in_byte    = '0;
        i_file_start = 1'b0;
        opts         = '0;
        line_no      = 20'd1;
        line_start   = 3'd1;
        n_errors     = 0;
        tx_idle_pct  = 35;
        rx_idle_pct  = 75;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_plain_bytes();
        test_caret_escapes();
        test_squeezed_numbering();
        test_blank_marker();
        test_random_text('0, 45);
        test_random_text('1, 45);

        tx_idle_pct = 75;
        rx_idle_pct = 35;
        test_random_text(6'($urandom_range(63)), 45);
        test_random_text(6'($urandom_range(63)), 45);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_text(6'($urandom_range(63)), 45);
        test_random_text(6'($urandom_range(63)), 45);

        wait_idle();
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
